[design/slp_pkg.sv]
// Package for the structure record parser.
// Parse phases, event codes, record type characters and shared structs.
// No dependencies.
package slp_pkg;

  localparam int SLP_QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_TYPECODE  = 4'd1,
    PH_ELEMBITS  = 4'd2,
    PH_OFFSET    = 4'd3,
    PH_ARRAYSIZE = 4'd4,
    PH_NAMELEN   = 4'd5,
    PH_NAMEBYTES = 4'd6,
    PH_PREVLEN   = 4'd7,
    PH_PREVBYTES = 4'd8
  } phase_t;

  localparam logic [3:0] EV_START     = 4'd0;
  localparam logic [3:0] EV_TYPECODE  = 4'd1;
  localparam logic [3:0] EV_ELEMBITS  = 4'd2;
  localparam logic [3:0] EV_OFFSET    = 4'd3;
  localparam logic [3:0] EV_ARRAYSIZE = 4'd4;
  localparam logic [3:0] EV_NAMELEN   = 4'd5;
  localparam logic [3:0] EV_NAMEBYTE  = 4'd6;
  localparam logic [3:0] EV_PREVLEN   = 4'd7;
  localparam logic [3:0] EV_PREVBYTE  = 4'd8;
  localparam logic [3:0] EV_STOP      = 4'd9;
  localparam logic [3:0] EV_TRUNC     = 4'd10;

  localparam logic [7:0] CH_OPEN  = 8'h7b;  // '{'
  localparam logic [7:0] CH_FIELD = 8'h46;  // 'F'
  localparam logic [7:0] CH_ITEM  = 8'h49;  // 'I'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  localparam logic [6:0] LEB_STEP  = 7'd7;
  localparam logic [6:0] LEB_LIMIT = 7'd64;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [7:0]  record_type;
    logic [63:0] event_value;
    logic        record_last;
  } result_t;

  typedef struct packed {
    logic   stopped;
    phase_t phase;
  } core_status_t;

endpackage

[design/slp_if.sv]
// Handshake interfaces for the structure record parser.
// Byte input channel and event output channel; depends on nothing.
interface slp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface slp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [7:0]  record_type;
  logic [63:0] event_value;
  logic        record_last;

  modport source (output valid, output event_kind, output record_type, output event_value,
                  output record_last, input ready);
  modport sink   (input valid, input event_kind, input record_type, input event_value,
                  input record_last, output ready);
endinterface

[design/slp_core.sv]
// Parser state and per-byte decode for the structure record parser.
// Uses slp_pkg; produces at most one result per transfer.
module slp_core
  import slp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   stream_byte,
  input  logic         end_of_stream,
  output logic         res_valid,
  output result_t      res,
  output core_status_t status
);

  phase_t      phase, phase_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [63:0] acc, acc_next;
  logic [6:0]  shift, shift_next;
  logic [63:0] remaining, remaining_next;
  logic        stopped, stopped_next;

  logic [63:0] leb_add;
  logic [63:0] leb_val;
  logic [6:0]  shift_inc;
  logic [63:0] rem_dec;
  logic [7:0]  digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cur_type  <= '0;
      acc       <= '0;
      shift     <= '0;
      remaining <= '0;
      stopped   <= 1'b0;
    end else begin
      phase     <= phase_next;
      cur_type  <= cur_type_next;
      acc       <= acc_next;
      shift     <= shift_next;
      remaining <= remaining_next;
      stopped   <= stopped_next;
    end
  end

  assign leb_add   = (shift < LEB_LIMIT) ? (64'(stream_byte[6:0]) << shift[5:0]) : '0;
  assign leb_val   = acc | leb_add;
  assign shift_inc = (shift < LEB_LIMIT) ? shift + LEB_STEP : shift;
  assign rem_dec   = remaining - 64'd1;
  assign digit     = stream_byte - CH_ZERO;

  always_comb begin
    phase_next     = phase;
    cur_type_next  = cur_type;
    acc_next       = acc;
    shift_next     = shift;
    remaining_next = remaining;
    stopped_next   = stopped;
    res_valid      = 1'b0;
    res            = '{event_kind: EV_STOP, record_type: cur_type, event_value: '0,
                       record_last: 1'b0};

    if (accept && !stopped) begin
      if (end_of_stream) begin
        stopped_next    = 1'b1;
        res_valid       = 1'b1;
        res.record_last = 1'b1;
        if (phase == PH_IDLE) begin
          res.event_kind  = EV_STOP;
          res.record_type = '0;
        end else begin
          res.event_kind = EV_TRUNC;
          phase_next     = PH_IDLE;
        end
      end else begin
        case (phase)
          PH_IDLE: begin
            res_valid = 1'b1;
            if (stream_byte == 8'd0) begin
              stopped_next    = 1'b1;
              cur_type_next   = '0;
              res.event_kind  = EV_STOP;
              res.record_type = '0;
              res.record_last = 1'b1;
            end else begin
              cur_type_next   = stream_byte;
              acc_next        = '0;
              shift_next      = '0;
              res.event_kind  = EV_START;
              res.record_type = stream_byte;
              res.event_value = 64'(stream_byte);
              if (stream_byte == CH_OPEN || stream_byte == CH_ITEM) begin
                phase_next = PH_NAMELEN;
              end else if (stream_byte == CH_FIELD) begin
                phase_next = PH_TYPECODE;
              end else begin
                res.record_last = 1'b1;
              end
            end
          end
          PH_TYPECODE: begin
            phase_next      = PH_ELEMBITS;
            res_valid       = 1'b1;
            res.event_kind  = EV_TYPECODE;
            res.event_value = 64'(stream_byte);
          end
          PH_ELEMBITS: begin
            phase_next      = PH_OFFSET;
            acc_next        = '0;
            shift_next      = '0;
            res_valid       = 1'b1;
            res.event_kind  = EV_ELEMBITS;
            res.event_value = 64'({digit[4:0], 3'b000});
          end
          PH_OFFSET, PH_ARRAYSIZE, PH_NAMELEN, PH_PREVLEN: begin
            if (stream_byte[7]) begin
              acc_next   = leb_val;
              shift_next = shift_inc;
            end else begin
              acc_next        = '0;
              shift_next      = '0;
              res_valid       = 1'b1;
              res.event_value = leb_val;
              case (phase)
                PH_OFFSET: begin
                  res.event_kind = EV_OFFSET;
                  phase_next     = PH_ARRAYSIZE;
                end
                PH_ARRAYSIZE: begin
                  res.event_kind = EV_ARRAYSIZE;
                  phase_next     = PH_NAMELEN;
                end
                PH_NAMELEN: begin
                  res.event_kind = EV_NAMELEN;
                  remaining_next = leb_val;
                  if (leb_val != '0) begin
                    phase_next = PH_NAMEBYTES;
                  end else if (cur_type == CH_OPEN) begin
                    phase_next      = PH_IDLE;
                    res.record_last = 1'b1;
                  end else begin
                    phase_next = PH_PREVLEN;
                  end
                end
                default: begin
                  res.event_kind = EV_PREVLEN;
                  remaining_next = leb_val;
                  if (leb_val != '0) begin
                    phase_next = PH_PREVBYTES;
                  end else begin
                    phase_next      = PH_IDLE;
                    res.record_last = 1'b1;
                  end
                end
              endcase
            end
          end
          PH_NAMEBYTES: begin
            remaining_next  = rem_dec;
            res_valid       = 1'b1;
            res.event_kind  = EV_NAMEBYTE;
            res.event_value = 64'(stream_byte);
            if (rem_dec == '0) begin
              if (cur_type == CH_OPEN) begin
                phase_next      = PH_IDLE;
                res.record_last = 1'b1;
              end else begin
                phase_next = PH_PREVLEN;
                acc_next   = '0;
                shift_next = '0;
              end
            end
          end
          PH_PREVBYTES: begin
            remaining_next  = rem_dec;
            res_valid       = 1'b1;
            res.event_kind  = EV_PREVBYTE;
            res.event_value = 64'(stream_byte);
            if (rem_dec == '0) begin
              phase_next      = PH_IDLE;
              res.record_last = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign status = '{stopped: stopped, phase: phase};

endmodule

[design/slp_outq.sv]
// Result queue for the structure record parser.
// Small register queue that parts the parser from the event channel; uses slp_pkg.
module slp_outq
  import slp_pkg::*;
#(
  parameter int DEPTH = SLP_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         slots [DEPTH];
  logic [IW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign has_room  = (count != CW'(DEPTH));
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/structure_record_parser.sv]
// Structure record parser: one stream byte per transfer, at most one event out per byte.
// Each byte is decoded in the cycle it is taken and its event lands in a small result
// queue, so the block takes one byte every cycle while the event side keeps up; it only
// holds off input when the queue (QUEUE_DEPTH entries) is full. Once a stop or truncated
// event has been produced, further bytes are taken and dropped until reset.
// Depends on slp_pkg, slp_if, slp_core and slp_outq.
module structure_record_parser
  import slp_pkg::*;
#(
  parameter int QUEUE_DEPTH = SLP_QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  slp_in_if.sink    stream,
  slp_out_if.source events
);

  logic         accept;
  logic         res_valid;
  result_t      res;
  core_status_t status;
  logic         has_room;
  result_t      head;

  assign stream.ready = has_room;
  assign accept       = stream.valid && stream.ready;

  slp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .stream_byte   (stream.stream_byte),
    .end_of_stream (stream.end_of_stream),
    .res_valid     (res_valid),
    .res           (res),
    .status        (status)
  );

  slp_outq #(.DEPTH(QUEUE_DEPTH)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (has_room),
    .pop_valid (events.valid),
    .pop_ready (events.ready),
    .pop_data  (head)
  );

  assign events.event_kind  = head.event_kind;
  assign events.record_type = head.record_type;
  assign events.event_value = head.event_value;
  assign events.record_last = head.record_last;

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    status.stopped |-> !res_valid)
    else $error("result produced after stop");

  a_eos_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && !status.stopped && stream.end_of_stream) |-> (res_valid && res.record_last)
    ##1 status.stopped)
    else $error("end of stream did not close the parser");

  a_stop_event: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.event_kind == EV_STOP || res.event_kind == EV_TRUNC)) |=>
    (status.stopped && status.phase == PH_IDLE))
    else $error("stop event without stopped state");

endmodule
